// ----- src/assert_macros.svh -----
// Assertion macros used by the scanner core to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with asynchronous active-low reset.
`define ADCS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same, but the property must also hold while reset is asserted.
`define ADCS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/adcs_pkg.sv -----
// Types and constants of the ADC round-robin scanner.
`default_nettype none

package adcs_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	localparam int SLOT_W    = 4;
	localparam int SAMPLE_W  = 12;
	localparam int CHAN_W    = 5;
	localparam int UNIT_W    = 2;
	localparam int MAP_W     = CHAN_W + UNIT_W;
	localparam int MASK_W    = 16;
	localparam int MAPREG_W  = 56;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = MAPREG_W;

	// request codes
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_SEED = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_SLOT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH     = 2'd3;

	typedef struct packed {
		logic [1:0]          req_type;
		logic                conv_done;
		logic [SAMPLE_W-1:0] sample;
		logic [SLOT_W-1:0]   slot;
	} req_item_t;

	typedef struct packed {
		logic                start_conv;
		logic [CHAN_W-1:0]   conv_channel;
		logic [UNIT_W-1:0]   conv_unit;
		logic [SLOT_W-1:0]   conv_slot;
		logic                read_valid;
		logic [SAMPLE_W-1:0] read_value;
	} rsp_item_t;

	// slot after s, wrapping to zero past last (or from any slot above it)
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
			input logic [SLOT_W-1:0] last);
		logic [SLOT_W-1:0] n;
		n = s + 1'b1;
		if (s >= last || n > last) begin
			n = '0;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- src/adcs_req_if.sv -----
// Request channel of the scanner: valid/ready with one request item.
`default_nettype none

interface adcs_req_if import adcs_pkg::*; ;
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/adcs_rsp_if.sv -----
// Response channel of the scanner: valid/ready with one result item.
`default_nettype none

interface adcs_rsp_if import adcs_pkg::*; ;
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/adc_round_robin_scanner_core.sv -----
// Round-robin ADC slot scanner: sample store, slot search sequencer, result register.
`default_nettype none
`include "assert_macros.svh"

// Reads, seeds and unknown requests load their result in the cycle they are taken. So does a
// scan tick that is still waiting for its conversion (conv_done low), or that meets an empty
// enable mask. Otherwise the tick stores the finished sample if one was awaited, then a search
// sequencer tests one slot per cycle while the output register is free, with a single
// slot-enable check and next-slot step, examining up to NUM_SLOTS+1 slots. The request
// side is not ready while a search runs. Each request gives exactly one result, held in an
// output register; a new request is taken while the previous result is being taken.
// The sample store is flip-flops cleared by reset; no clearing pass is needed.
module adc_round_robin_scanner_core import adcs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	adcs_req_if.sink                  req,
	adcs_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int STORE_DEPTH = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
	localparam logic [5:0]       NSLOT6   = 6'(NUM_SLOTS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SRCH = 1'b1;

	// configuration
	logic [MASK_W-1:0]     mask_q;
	logic [SLOT_W-1:0]     last_q;
	logic [2*MAPREG_W-1:0] map_q;

	// scanner state
	logic                  state_q, state_d;
	logic [SLOT_W-1:0]     cur_q, cur_d;
	logic                  await_q, await_d;
	logic [SLOT_W-1:0]     srch_q, srch_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [SAMPLE_W-1:0]   store_q [STORE_DEPTH];

	// result register
	logic                  out_valid_q;
	rsp_item_t             out_q, out_d;
	logic                  load_out;
	logic                  out_free;

	logic                  acc;
	req_item_t             in_d;
	logic                  st_we;
	logic [SLOT_W-1:0]     st_slot;
	logic [SAMPLE_W-1:0]   st_data;
	logic [SLOT_W-1:0]     base;
	logic                  rd_on;
	logic                  srch_on;
	logic [MAP_W-1:0]      srch_map;
	logic [6:0]            map_ofs;

	function automatic logic in_range(input logic [SLOT_W-1:0] s);
		return {2'b00, s} < NSLOT6;
	endfunction

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign in_d      = req.data;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign rd_on    = in_range(in_d.slot) && mask_q[in_d.slot];
	assign srch_on  = in_range(srch_q) && mask_q[srch_q];
	assign map_ofs  = 7'(srch_q) * 7'd7;
	assign srch_map = map_q[map_ofs +: MAP_W];

	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		await_d  = await_q;
		srch_d   = srch_q;
		cnt_d    = cnt_q;
		load_out = 1'b0;
		out_d    = '0;
		st_we    = 1'b0;
		st_slot  = in_d.slot;
		st_data  = in_d.sample;
		base     = cur_q;
		if (acc) begin
			case (in_d.req_type)
				REQ_TICK: begin
					if (await_q && !in_d.conv_done) begin
						load_out = 1'b1;
					end else begin
						if (await_q) begin
							st_we   = in_range(cur_q);
							st_slot = cur_q;
							await_d = 1'b0;
							base    = next_slot(cur_q, last_q);
							cur_d   = base;
						end
						if (mask_q == '0) begin
							load_out = 1'b1;
						end else begin
							state_d = ST_SRCH;
							srch_d  = base;
							cnt_d   = '0;
						end
					end
				end
				REQ_READ: begin
					load_out         = 1'b1;
					out_d.read_valid = rd_on;
					out_d.read_value = rd_on ? store_q[in_d.slot[IDX_W-1:0]] : '0;
				end
				REQ_SEED: begin
					load_out = 1'b1;
					st_we    = in_range(in_d.slot);
				end
				default: begin
					load_out = 1'b1;
				end
			endcase
		end else if (state_q == ST_SRCH && out_free) begin
			if (srch_on) begin
				load_out           = 1'b1;
				out_d.start_conv   = 1'b1;
				out_d.conv_channel = srch_map[CHAN_W-1:0];
				out_d.conv_unit    = srch_map[MAP_W-1:CHAN_W];
				out_d.conv_slot    = srch_q;
				cur_d              = srch_q;
				await_d            = 1'b1;
				state_d            = ST_IDLE;
			end else if (cnt_q == CNT_LAST) begin
				// every reachable slot tried: no start
				load_out = 1'b1;
				state_d  = ST_IDLE;
			end else begin
				srch_d = next_slot(srch_q, last_q);
				cnt_d  = cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			last_q <= '0;
			map_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ENABLED_MASK: mask_q <= cfg_wdata[MASK_W-1:0];
				CFG_LAST_SLOT:    last_q <= cfg_wdata[SLOT_W-1:0];
				CFG_MAP_LOW:      map_q[MAPREG_W-1:0] <= cfg_wdata[MAPREG_W-1:0];
				CFG_MAP_HIGH:     map_q[2*MAPREG_W-1:MAPREG_W] <= cfg_wdata[MAPREG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			await_q     <= 1'b0;
			srch_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			await_q <= await_d;
			srch_q  <= srch_d;
			cnt_q   <= cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (st_we) begin
			store_q[st_slot[IDX_W-1:0]] <= st_data;
		end
	end

	`ADCS_ASSERT(a_no_req_in_search, clk, arst_n, (state_q == ST_SRCH) |-> !req.ready, "request taken during slot search")
	`ADCS_ASSERT(a_start_sets_wait, clk, arst_n, (load_out && out_d.start_conv) |=> (await_q && out_q.conv_slot == cur_q), "start without wait on its slot")
	`ADCS_ASSERT(a_search_bound, clk, arst_n, (state_q == ST_SRCH) |-> (cnt_q <= CNT_LAST), "slot search ran past its bound")
	`ADCS_ASSERT_ALWAYS(a_out_hold, clk, (!arst_n) |-> !out_valid_q, "result valid during reset")

endmodule

`default_nettype wire
